@@ hw/rtl/fdm_pkg.sv @@
// fdm_pkg: shared constants, register codes and the issue control struct
// for the frame difference morphology block
// no dependencies; compiled first
package fdm_pkg;

    // frame geometry and field widths
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int NUM_STAGES    = 3;
    localparam int PIX_W         = 8;
    localparam int FW_W          = 11;
    localparam int FH_W          = 12;
    localparam int ROW_W         = FH_W + 1;
    localparam int WIN_W         = 9;
    localparam int WORD_W        = 2 * NUM_STAGES;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // register reset values and clamp floor
    localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);
    localparam int              MIN_DIM      = 3;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    // per-item control captured at accept, used at write-back
    typedef struct packed {
        logic [NUM_STAGES-1:0] run;
        logic [NUM_STAGES-1:0] inner;
        logic                  bit0;
        logic                  emit;
        logic                  last;
    } issue_t;

endpackage

@@ hw/rtl/fdm_if.sv @@
// fdm_if: valid/ready stream interfaces for pixel pairs and result items
// depends on fdm_pkg for field widths
interface fdm_in_if;
    logic                       valid;
    logic                       ready;
    logic [fdm_pkg::PIX_W-1:0]  pixel_a;
    logic [fdm_pkg::PIX_W-1:0]  pixel_b;
    logic                       is_fill;

    modport source (output valid, output pixel_a, output pixel_b, output is_fill,
                    input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input is_fill,
                    output ready);
endinterface

interface fdm_out_if;
    logic valid;
    logic ready;
    logic result_on;
    logic last_of_frame;

    modport source (output valid, output result_on, output last_of_frame, input ready);
    modport sink   (input valid, input result_on, input last_of_frame, output ready);
endinterface

@@ hw/rtl/frame_difference_morphology_3x3.sv @@
// Throughput: one item per clock unless a stalled output holds the issue stage; an output
// register parts the result side. The line memory is read at the accept edge; windows,
// write-back and the output register follow when the item leaves the issue stage.
// Raster position p is reported with item p + 3*(frame_width+1).
// Reset (async, rst_n low): counters, windows and handshakes cleared, registers
// go to 640 x 480; the line memory is not cleared, rows are rewritten before use.
module frame_difference_morphology_3x3 #(
    parameter int MAX_WIDTH = fdm_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fdm_in_if.sink                      pix_in,
    fdm_out_if.source                   res_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdm_pkg::ADDR_W-1:0]  paddr,
    input  logic [fdm_pkg::DATA_W-1:0]  pwdata,
    output logic [fdm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NS = fdm_pkg::NUM_STAGES;
    localparam int RW = fdm_pkg::ROW_W;

    logic [fdm_pkg::FW_W-1:0] width_reg;
    logic [fdm_pkg::FH_W-1:0] height_reg;
    logic                     cfg_wr;
    fdm_pkg::reg_idx_t        cfg_idx;

    logic [CW-1:0]            wm1;
    logic [RW-1:0]            h_ext;
    logic [RW-1:0]            hp1;

    logic [CW-1:0]            col_reg  [NS];
    logic [CW-1:0]            col_next [NS];
    logic [RW-1:0]            row_reg  [NS];
    logic [RW-1:0]            row_next [NS];
    logic [NS-1:0]            act_reg;
    logic [NS-1:0]            act_next;

    fdm_pkg::issue_t          issue;
    logic                     accept;
    logic                     advance;
    logic                     p1_valid_reg;
    logic                     p1_valid_next;
    fdm_pkg::issue_t          p1_ctl_reg;
    logic [CW-1:0]            p1_addr_reg;

    logic                     res_bit;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     result_on_reg;
    logic                     last_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = fdm_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fdm_pkg::RESET_WIDTH;
            height_reg <= fdm_pkg::RESET_HEIGHT;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                fdm_pkg::REG_WIDTH:  width_reg  <= pwdata[fdm_pkg::FW_W-1:0];
                fdm_pkg::REG_HEIGHT: height_reg <= pwdata[fdm_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            fdm_pkg::REG_WIDTH:  prdata = fdm_pkg::DATA_W'(width_reg);
            fdm_pkg::REG_HEIGHT: prdata = fdm_pkg::DATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // effective geometry: width clamped to 3..MAX_WIDTH, height at least 3
    always_comb
    begin
        if (width_reg < fdm_pkg::FW_W'(fdm_pkg::MIN_DIM))
        begin
            wm1 = CW'(fdm_pkg::MIN_DIM - 1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            wm1 = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            wm1 = CW'(width_reg - fdm_pkg::FW_W'(1));
        end
        if (height_reg < fdm_pkg::FH_W'(fdm_pkg::MIN_DIM))
        begin
            h_ext = RW'(fdm_pkg::MIN_DIM);
        end
        else
        begin
            h_ext = RW'(height_reg);
        end
        hp1 = h_ext + RW'(1);
    end

    // per-item control: which stages run, border flags, difference bit, emit and last
    always_comb
    begin
        issue.run[0] = 1'b1;
        for (int k = 1; k < NS; k++)
        begin
            issue.run[k] = act_reg[k-1] || (issue.run[k-1] &&
                           row_reg[k-1] == RW'(1) && col_reg[k-1] == CW'(1));
        end
        for (int k = 0; k < NS; k++)
        begin
            issue.inner[k] = row_reg[k] >= RW'(2) && row_reg[k] < h_ext &&
                             col_reg[k] >= CW'(2);
        end
        issue.emit = act_reg[NS-1] || (issue.run[NS-1] &&
                     row_reg[NS-1] == RW'(1) && col_reg[NS-1] == CW'(1));
        issue.last = issue.run[NS-1] && row_reg[NS-1] == hp1 &&
                     col_reg[NS-1] == CW'(0);
        issue.bit0 = row_reg[0] < h_ext && !pix_in.is_fill &&
                     ((pix_in.pixel_a ^ pix_in.pixel_b) != '0);
    end

    // position counters per stage; all share the stage 0 column as memory address
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        act_next = act_reg;
        if (cfg_wr)
        begin
            col_next = '{default: '0};
            row_next = '{default: '0};
            act_next = '0;
        end
        else if (accept)
        begin
            if (issue.last)
            begin
                col_next = '{default: '0};
                row_next = '{default: '0};
                act_next = '0;
            end
            else
            begin
                for (int k = 0; k < NS; k++)
                begin
                    if (issue.run[k])
                    begin
                        if (col_reg[k] == wm1)
                        begin
                            col_next[k] = '0;
                            row_next[k] = row_reg[k] + RW'(1);
                        end
                        else
                        begin
                            col_next[k] = col_reg[k] + CW'(1);
                        end
                    end
                end
                act_next = {issue.emit, issue.run[NS-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '{default: '0};
            row_reg <= '{default: '0};
            act_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            act_reg <= act_next;
        end
    end

    // handshake: issue stage holds an item for its memory read or behind a stalled output
    assign advance = p1_valid_reg && (!p1_ctl_reg.emit || !out_valid_reg || res_out.ready);
    assign pix_in.ready = !p1_valid_reg || advance;
    assign accept = pix_in.valid && pix_in.ready;

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_ctl_reg  <= issue;
            p1_addr_reg <= col_reg[0];
        end
    end

    // line memory and windows
    fdm_morph #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_morph (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg[0]),
        .wr_en   (advance),
        .wr_addr (p1_addr_reg),
        .ctl     (p1_ctl_reg),
        .clr     (cfg_wr),
        .result  (res_bit)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && p1_ctl_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && p1_ctl_reg.emit)
        begin
            result_on_reg <= res_bit;
            last_reg      <= p1_ctl_reg.last;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.result_on     = result_on_reg;
    assign res_out.last_of_frame = last_reg;

endmodule

@@ hw/rtl/fdm_morph.sv @@
// fdm_morph: shared line memory for all three stages plus the 3x3 windows
// reads a word at accept, erodes twice and dilates once, writes the word back
// depends on fdm_pkg
module fdm_morph #(
    parameter int MAX_WIDTH = fdm_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  fdm_pkg::issue_t                 ctl,
    input  logic                            clr,
    output logic                            result
);

    // one word per column: {line1, line0} for each stage, stage k in bits 2k+1:2k
    logic [fdm_pkg::WORD_W-1:0] line_mem [MAX_WIDTH];
    logic [fdm_pkg::WORD_W-1:0] rd_data_reg;
    logic [fdm_pkg::WORD_W-1:0] wr_word;

    logic [fdm_pkg::WIN_W-1:0]  win_reg  [fdm_pkg::NUM_STAGES];
    logic [fdm_pkg::WIN_W-1:0]  win_next [fdm_pkg::NUM_STAGES];

    // memory, read-first, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_word;
        end
    end

    // window shift and stage chain: erosion, erosion, dilation
    always_comb
    begin
        logic stage_bit;
        logic l0;
        logic l1;
        stage_bit = ctl.bit0;
        wr_word   = rd_data_reg;
        for (int k = 0; k < fdm_pkg::NUM_STAGES; k++)
        begin
            l0 = rd_data_reg[2*k];
            l1 = rd_data_reg[2*k+1];
            win_next[k] = win_reg[k];
            if (ctl.run[k])
            begin
                win_next[k]       = {win_reg[k][fdm_pkg::WIN_W-4:0], l1, l0, stage_bit};
                wr_word[2*k +: 2] = {l0, stage_bit};
            end
            if (k == fdm_pkg::NUM_STAGES - 1)
            begin
                stage_bit = ctl.inner[k] && (|win_next[k]);
            end
            else
            begin
                stage_bit = ctl.inner[k] && (&win_next[k]);
            end
        end
        result = stage_bit;
    end

    // windows restart with the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '{default: '0};
        end
        else if (clr)
        begin
            win_reg <= '{default: '0};
        end
        else if (wr_en)
        begin
            if (ctl.last)
            begin
                win_reg <= '{default: '0};
            end
            else
            begin
                win_reg <= win_next;
            end
        end
    end

endmodule

@@ hw/rtl/fdm_checker.sv @@
// fdm_checker: port-level assertions for the frame difference morphology block
// depends on fdm_pkg; bound to the top level at the end of this file
module fdm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        result_on,
    input logic                        last_of_frame,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [fdm_pkg::ADDR_W-1:0]  paddr,
    input logic [fdm_pkg::DATA_W-1:0]  pwdata,
    input logic [fdm_pkg::DATA_W-1:0]  prdata
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_on) && $stable(last_of_frame))
        else $error("result item changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // a free output side never blocks an offered item
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && out_ready |-> in_ready)
        else $error("input stalled while output is ready");

    // width register reads back what was written
    a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2] == fdm_pkg::REG_WIDTH)
        ##1 (psel && !pwrite && paddr[2] == fdm_pkg::REG_WIDTH)
        |-> prdata[fdm_pkg::FW_W-1:0] == $past(pwdata[fdm_pkg::FW_W-1:0]))
        else $error("width register read back wrong");

endmodule

bind frame_difference_morphology_3x3 fdm_checker u_fdm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix_in.valid),
    .in_ready      (pix_in.ready),
    .out_valid     (res_out.valid),
    .out_ready     (res_out.ready),
    .result_on     (res_out.result_on),
    .last_of_frame (res_out.last_of_frame),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
